// ===== sv/grid_dijkstra_path_search_core_assert.svh =====
// assertion macros for the grid path search core
`ifndef GRID_DIJKSTRA_PATH_SEARCH_CORE_ASSERT_SVH
`define GRID_DIJKSTRA_PATH_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define GDPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdps assertion failed");

// next-cycle implication
`define GDPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdps assertion failed");

`endif

// ===== sv/gdps_pkg.sv =====
// types, codes and direction tables of the grid path search core
package gdps_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        CFG_ROWS  = 3'd0,
        CFG_COLS  = 3'd1,
        CFG_CUT   = 3'd2,
        CFG_SCOST = 3'd3,
        CFG_DCOST = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CS_UNSEEN = 2'd0,
        CS_OPEN   = 2'd1,
        CS_CLOSED = 2'd2
    } t_cell_status;

    function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd0, 3'd1, 3'd2: v = -2'sd1;
            3'd3, 3'd4:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd0, 3'd3, 3'd5: v = -2'sd1;
            3'd1, 3'd6:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic dir_diag(input logic [2:0] d);
        return (dir_dx(d) != 2'sd0) && (dir_dy(d) != 2'sd0);
    endfunction

endpackage

// ===== sv/gdps_obstacle_map.sv =====
// obstacle bit memory with clearing pass after reset
module gdps_obstacle_map #(
    parameter int CW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [CW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [CW-1:0] i_raddr,
    output logic          o_rdata,
    output logic          o_busy
);
    logic          mem [2**CW];
    logic [CW:0]   r_sweep;
    logic          r_rdata;

    assign o_busy  = !r_sweep[CW];
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (o_busy) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            mem[r_sweep[CW-1:0]] <= 1'b0;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end
endmodule

// ===== sv/grid_dijkstra_path_search_core.sv =====
// top level of the grid path search core: control, node memories and stream ports
//
//  channel   | direction | accepted when
//  s_axis    | in        | s_axis_tvalid && s_axis_tready
//  m_axis    | out       | m_axis_tvalid && m_axis_tready
//  cfg write | in        | i_cfg_valid && o_cfg_ready
//
// load and read requests: one per cycle while no result is stalled, result in the cycle after acceptance
// search: full status clear and opening of the start, then per expansion a scan of the
//   inserted cells in the list plus a check of each neighbor, then a parent walk over the
//   path cells and the report; one node memory port sets this
// after reset the obstacle map is cleared, no request taken
// a stalled result holds further requests off; config is always taken
`include "grid_dijkstra_path_search_core_assert.svh"
module grid_dijkstra_path_search_core
    import gdps_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x, cell_y, blocked, start_x, start_y, goal_x, goal_y, path_index, zero fill
    input  logic [55:0] s_axis_tdata,
    // action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found, path_length, step_x, step_y, index_ok, zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int XW     = $clog2(MAX_ROWS);
    localparam int YW     = $clog2(MAX_COLS);
    localparam int CW     = XW + YW;
    localparam int XE     = XW + 2;
    localparam int YE     = YW + 2;
    localparam int NCELLS = MAX_ROWS * MAX_COLS;
    localparam int NW     = $clog2(NCELLS + 1);
    localparam int PW     = $clog2(NCELLS);
    localparam int COST_W = 8 + PW;
    localparam int NODE_W = COST_W + 5;

    typedef enum logic [14:0] {
        ST_INIT   = 15'b000000000000001,
        ST_IDLE   = 15'b000000000000010,
        ST_CLEAR  = 15'b000000000000100,
        ST_OPEN   = 15'b000000000001000,
        ST_SCAN   = 15'b000000000010000,
        ST_NB0    = 15'b000000000100000,
        ST_NB1    = 15'b000000001000000,
        ST_NB2    = 15'b000000010000000,
        ST_NB3    = 15'b000000100000000,
        ST_NB4    = 15'b000001000000000,
        ST_WALK1A = 15'b000010000000000,
        ST_WALK1B = 15'b000100000000000,
        ST_WALK2A = 15'b001000000000000,
        ST_WALK2B = 15'b010000000000000,
        ST_DONE   = 15'b100000000000000
    } t_state;

    // memories
    logic [NODE_W-1:0] node_mem  [2**CW];
    logic [CW-1:0]     order_mem [NCELLS];
    logic [CW-1:0]     path_mem  [NCELLS];

    // registers
    t_state            r_state, n_state;
    logic [6:0]        r_rows, r_cols;
    logic              r_cut;
    logic [7:0]        r_scost, r_dcost;
    logic [CW-1:0]     r_s, n_s, r_g, n_g;
    logic [11:0]       r_idx, n_idx;
    logic              r_found, n_found;
    logic [NW-1:0]     r_pcount, n_pcount;
    logic [NW-1:0]     r_ins, n_ins;
    logic [CW:0]       r_sweep, n_sweep;
    logic [NW-1:0]     r_k, n_k;
    logic              r_p1, n_p1, r_p2, n_p2;
    logic [CW-1:0]     r_c2, n_c2;
    logic              r_have, n_have;
    logic [CW-1:0]     r_best, n_best;
    logic [COST_W-1:0] r_best_cost, n_best_cost;
    logic [2:0]        r_best_par, n_best_par;
    logic [2:0]        r_d, n_d;
    logic [CW-1:0]     r_t, n_t;
    logic [CW-1:0]     r_cur, n_cur;
    logic [NW-1:0]     r_n, n_n;
    logic              r_ov, n_ov;
    logic              r_iok, n_iok;
    logic [CW-1:0]     r_ord_q;
    logic [NODE_W-1:0] r_node_q;
    logic [CW-1:0]     r_path_q;

    // memory controls
    logic              node_we, node_re, order_we, order_re, path_we, path_re;
    logic [CW-1:0]     node_waddr, node_raddr, order_wdata, path_wdata;
    logic [NODE_W-1:0] node_wdata;
    logic [PW-1:0]     order_waddr, path_waddr, path_raddr;
    logic              obs_we, obs_wdata, obs_re, obs_q, obs_busy;
    logic [CW-1:0]     obs_waddr, obs_raddr;

    // request fields
    t_action           in_act;
    logic [5:0]        in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
    logic              in_blk, in_acc;
    logic [11:0]       in_idx;

    logic [XE-1:0]     rows_eff;
    logic [YE-1:0]     cols_eff;
    logic signed [XE-1:0] tx;
    logic signed [YE-1:0] ty;
    logic              t_in;
    logic [CW-1:0]     t_cell;
    logic [1:0]        q_status;
    logic [COST_W-1:0] q_cost, nc;
    logic              d_diag;

    assign in_act = t_action'(s_axis_tuser);
    assign in_cx  = s_axis_tdata[5:0];
    assign in_cy  = s_axis_tdata[11:6];
    assign in_blk = s_axis_tdata[12];
    assign in_sx  = s_axis_tdata[18:13];
    assign in_sy  = s_axis_tdata[24:19];
    assign in_gx  = s_axis_tdata[30:25];
    assign in_gy  = s_axis_tdata[36:31];
    assign in_idx = s_axis_tdata[48:37];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ov || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b0, r_iok,
                            (r_iok ? 6'(r_path_q[YW-1:0]) : 6'd0),
                            (r_iok ? 6'(r_path_q[CW-1:YW]) : 6'd0),
                            13'(r_pcount), r_found};

    always_comb begin
        if (r_rows == 7'd0) begin
            rows_eff = XE'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            rows_eff = XE'(MAX_ROWS);
        end else begin
            rows_eff = XE'(r_rows);
        end
        if (r_cols == 7'd0) begin
            cols_eff = YE'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            cols_eff = YE'(MAX_COLS);
        end else begin
            cols_eff = YE'(r_cols);
        end
    end

    // neighbor of the expanded cell in direction r_d
    assign tx     = $signed(XE'(r_best[CW-1:YW])) + XE'(dir_dx(r_d));
    assign ty     = $signed(YE'(r_best[YW-1:0])) + YE'(dir_dy(r_d));
    assign t_in   = !tx[XE-1] && !ty[YE-1] && ($unsigned(tx) < rows_eff)
                    && ($unsigned(ty) < cols_eff);
    assign t_cell = {tx[XW-1:0], ty[YW-1:0]};
    assign d_diag = dir_diag(r_d);

    assign q_status = r_node_q[NODE_W-1 -: 2];
    assign q_cost   = r_node_q[3 +: COST_W];
    assign nc       = r_best_cost + COST_W'(d_diag ? r_dcost : r_scost);

    always_comb begin
        n_state = r_state;   n_s = r_s;           n_g = r_g;
        n_idx = r_idx;       n_found = r_found;   n_pcount = r_pcount;
        n_ins = r_ins;       n_sweep = r_sweep;   n_k = r_k;
        n_p1 = 1'b0;         n_p2 = 1'b0;         n_c2 = r_c2;
        n_have = r_have;     n_best = r_best;     n_best_cost = r_best_cost;
        n_best_par = r_best_par; n_d = r_d;       n_t = r_t;
        n_cur = r_cur;       n_n = r_n;
        n_ov = r_ov && !m_axis_tready;
        n_iok = r_iok;
        node_we = 1'b0;  node_waddr = '0;  node_wdata = '0;
        node_re = 1'b0;  node_raddr = '0;
        order_we = 1'b0; order_waddr = '0; order_wdata = '0; order_re = 1'b0;
        path_we = 1'b0;  path_waddr = '0;  path_wdata = '0;
        path_re = 1'b0;  path_raddr = '0;
        obs_we = 1'b0;   obs_waddr = '0;   obs_wdata = 1'b0;
        obs_re = 1'b0;   obs_raddr = '0;

        unique case (r_state)
            ST_INIT: begin
                if (!obs_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_act)
                        ACT_LOAD: begin
                            obs_we    = (32'(in_cx) < MAX_ROWS) && (32'(in_cy) < MAX_COLS);
                            obs_waddr = {XW'(in_cx), YW'(in_cy)};
                            obs_wdata = in_blk;
                            n_ov  = 1'b1;
                            n_iok = 1'b0;
                        end
                        ACT_SEARCH: begin
                            n_s      = {XW'(in_sx), YW'(in_sy)};
                            n_g      = {XW'(in_gx), YW'(in_gy)};
                            n_idx    = in_idx;
                            n_found  = 1'b0;
                            n_pcount = '0;
                            n_ins    = '0;
                            if ((32'(in_sx) >= 32'(rows_eff)) || (32'(in_gx) >= 32'(rows_eff))
                                || (32'(in_sy) >= 32'(cols_eff))
                                || (32'(in_gy) >= 32'(cols_eff))) begin
                                n_state = ST_DONE;
                            end else if ((in_sx == in_gx) && (in_sy == in_gy)) begin
                                path_we    = 1'b1;
                                path_waddr = '0;
                                path_wdata = {XW'(in_sx), YW'(in_sy)};
                                n_pcount   = NW'(1);
                                n_found    = 1'b1;
                                n_state    = ST_DONE;
                            end else begin
                                n_sweep = '0;
                                n_state = ST_CLEAR;
                            end
                        end
                        ACT_READ: begin
                            path_re    = 32'(in_idx) < 32'(r_pcount);
                            path_raddr = PW'(in_idx);
                            n_iok      = path_re;
                            n_ov       = 1'b1;
                        end
                        default: begin
                            n_ov  = 1'b1;
                            n_iok = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = r_sweep[CW-1:0];
                node_wdata = {CS_UNSEEN, {(NODE_W-2){1'b0}}};
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep[CW-1:0] == {CW{1'b1}}) begin
                    n_state = ST_OPEN;
                end
            end
            ST_OPEN: begin
                node_we     = 1'b1;
                node_waddr  = r_s;
                node_wdata  = {CS_OPEN, {(NODE_W-2){1'b0}}};
                order_we    = 1'b1;
                order_waddr = '0;
                order_wdata = r_s;
                n_ins       = NW'(1);
                n_k         = '0;
                n_have      = 1'b0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_k < r_ins) begin
                    order_re = 1'b1;
                    n_k      = r_k + 1'b1;
                    n_p1     = 1'b1;
                end
                node_re    = r_p1;
                node_raddr = r_ord_q;
                n_p2       = r_p1;
                n_c2       = r_ord_q;
                if (r_p2 && (q_status == CS_OPEN) && (!r_have || (q_cost < r_best_cost))) begin
                    n_have      = 1'b1;
                    n_best      = r_c2;
                    n_best_cost = q_cost;
                    n_best_par  = r_node_q[2:0];
                end
                if ((r_k == r_ins) && !r_p1 && !r_p2) begin
                    if (!r_have) begin
                        n_state = ST_DONE;
                    end else begin
                        node_we    = 1'b1;
                        node_waddr = r_best;
                        node_wdata = {CS_CLOSED, r_best_cost, r_best_par};
                        n_d        = '0;
                        n_state    = ST_NB0;
                    end
                end
            end
            ST_NB0: begin
                if (t_in) begin
                    node_re    = 1'b1;
                    node_raddr = t_cell;
                    obs_re     = 1'b1;
                    obs_raddr  = t_cell;
                    n_t        = t_cell;
                    n_state    = ST_NB1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NB1: begin
                if (obs_q || (q_status == CS_CLOSED)) begin
                    n_state = ST_IDLE;
                end else if (d_diag && !r_cut) begin
                    obs_re    = 1'b1;
                    obs_raddr = {r_best[CW-1:YW], r_t[YW-1:0]};
                    n_state   = ST_NB2;
                end else begin
                    n_state = ST_NB4;
                end
            end
            ST_NB2: begin
                if (obs_q) begin
                    n_state = ST_IDLE;
                end else begin
                    obs_re    = 1'b1;
                    obs_raddr = {r_t[CW-1:YW], r_best[YW-1:0]};
                    n_state   = ST_NB3;
                end
            end
            ST_NB3: begin
                n_state = obs_q ? ST_IDLE : ST_NB4;
            end
            ST_NB4: begin
                n_state = ST_IDLE;
                if (q_status == CS_UNSEEN) begin
                    node_we     = 1'b1;
                    node_waddr  = r_t;
                    node_wdata  = {CS_OPEN, nc, r_d};
                    order_we    = 1'b1;
                    order_waddr = PW'(r_ins);
                    order_wdata = r_t;
                    n_ins       = r_ins + 1'b1;
                    if (r_t == r_g) begin
                        n_cur   = r_g;
                        n_n     = NW'(1);
                        n_state = ST_WALK1A;
                    end
                end else if (nc < q_cost) begin
                    node_we    = 1'b1;
                    node_waddr = r_t;
                    node_wdata = {CS_OPEN, nc, r_d};
                end
            end
            ST_WALK1A: begin
                if ((r_cur == r_s) || (r_n == NW'(NCELLS))) begin
                    n_pcount = r_n;
                    n_cur    = r_g;
                    n_state  = ST_WALK2A;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = r_cur;
                    n_state    = ST_WALK1B;
                end
            end
            ST_WALK1B: begin
                n_cur   = {r_cur[CW-1:YW] - XW'(dir_dx(r_node_q[2:0])),
                           r_cur[YW-1:0] - YW'(dir_dy(r_node_q[2:0]))};
                n_n     = r_n + 1'b1;
                n_state = ST_WALK1A;
            end
            ST_WALK2A: begin
                node_re    = 1'b1;
                node_raddr = r_cur;
                path_we    = 1'b1;
                path_waddr = PW'(r_n - 1'b1);
                path_wdata = r_cur;
                n_state    = ST_WALK2B;
            end
            ST_WALK2B: begin
                if (r_n == NW'(1)) begin
                    n_found = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_cur   = {r_cur[CW-1:YW] - XW'(dir_dx(r_node_q[2:0])),
                               r_cur[YW-1:0] - YW'(dir_dy(r_node_q[2:0]))};
                    n_n     = r_n - 1'b1;
                    n_state = ST_WALK2A;
                end
            end
            ST_DONE: begin
                path_re    = 32'(r_idx) < 32'(r_pcount);
                path_raddr = PW'(r_idx);
                n_iok      = path_re;
                n_ov       = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // neighbor step done without a hit: next direction or next expansion
        if (((r_state == ST_NB0) || (r_state == ST_NB1) || (r_state == ST_NB2)
             || (r_state == ST_NB3) || (r_state == ST_NB4)) && (n_state == ST_IDLE)) begin
            if (r_d == 3'd7) begin
                n_k     = '0;
                n_have  = 1'b0;
                n_state = ST_SCAN;
            end else begin
                n_d     = r_d + 1'b1;
                n_state = ST_NB0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_rows   <= 7'd64;
            r_cols   <= 7'd64;
            r_cut    <= 1'b0;
            r_scost  <= 8'd10;
            r_dcost  <= 8'd14;
            r_found  <= 1'b0;
            r_pcount <= '0;
            r_ins    <= '0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_ov     <= 1'b0;
            r_iok    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_found  <= n_found;
            r_pcount <= n_pcount;
            r_ins    <= n_ins;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_ov     <= n_ov;
            r_iok    <= n_iok;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_ROWS:  r_rows  <= i_cfg_data[6:0];
                    CFG_COLS:  r_cols  <= i_cfg_data[6:0];
                    CFG_CUT:   r_cut   <= i_cfg_data[0];
                    CFG_SCOST: r_scost <= i_cfg_data;
                    CFG_DCOST: r_dcost <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_g         <= n_g;
        r_idx       <= n_idx;
        r_sweep     <= n_sweep;
        r_k         <= n_k;
        r_c2        <= n_c2;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_cost <= n_best_cost;
        r_best_par  <= n_best_par;
        r_d         <= n_d;
        r_t         <= n_t;
        r_cur       <= n_cur;
        r_n         <= n_n;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_raddr];
        end
        if (order_we) begin
            order_mem[order_waddr] <= order_wdata;
        end
        if (order_re) begin
            r_ord_q <= order_mem[PW'(r_k)];
        end
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
        if (path_re) begin
            r_path_q <= path_mem[path_raddr];
        end
    end

    gdps_obstacle_map #(
        .CW(CW)
    ) u_obs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (obs_we),
        .i_waddr (obs_waddr),
        .i_wdata (obs_wdata),
        .i_re    (obs_re),
        .i_raddr (obs_raddr),
        .o_rdata (obs_q),
        .o_busy  (obs_busy)
    );

    `GDPS_ASSERT_IMP(a_stall_blocks_in, r_ov && !m_axis_tready, !s_axis_tready)
    `GDPS_ASSERT_IMP(a_found_has_path, r_found, r_pcount != '0)
    `GDPS_ASSERT_NXT(a_load_answers, in_acc && (in_act == ACT_LOAD), r_ov && !r_iok)
    `GDPS_ASSERT_IMP(a_open_list_bound, 1'b1, 32'(r_ins) <= NCELLS)
endmodule
